/* rtl/cfc_pkg.sv */
`default_nettype none
package cfc_pkg;
  localparam int unsigned WORD_WIDTH      = 32;
  localparam int unsigned DOUBLE_WIDTH    = 64;
  localparam int unsigned EXP_WIDTH_DEF   = 7;
  localparam int unsigned FRAC_WIDTH      = 52;
  localparam int unsigned BEXP_WIDTH      = 11;
  // biased exponent of 1.0: 1023
  localparam logic [BEXP_WIDTH-1:0] BIAS  = 11'd1023;
  // 1.0e-100 and 1.0e100 as magnitude bit patterns
  localparam logic [62:0] TINY_BITS = 63'h2B2BFF2EE48E0530;
  localparam logic [62:0] HUGE_BITS = 63'h54B249AD2594C37D;

  typedef enum logic {
    OP_ENCODE = 1'b0,
    OP_DECODE = 1'b1
  } op_t;
endpackage
`default_nettype wire

/* rtl/compact_float_codec_unit.sv */
`default_nettype none
// Channel | valid    | stall    | payload
// in      | in_valid | in_stall | opcode, double_bits, packed_word
// out     | valid    | stall    | packed_result, double_result
// Items pass input then result register; one item per cycle while not stalled.
// A single conversion stage sits between input and result registers.
// Reset clears only the valid flags.
// A stalled result holds; input is taken while the input register is empty or moving.
module compact_float_codec_unit #(
  parameter int unsigned EXP_WIDTH = cfc_pkg::EXP_WIDTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic                               opcode,
  input  wire logic [cfc_pkg::DOUBLE_WIDTH-1:0]   double_bits,
  input  wire logic [cfc_pkg::WORD_WIDTH-1:0]     packed_word,
  output logic                                    valid,
  input  wire logic                               stall,
  output logic      [cfc_pkg::WORD_WIDTH-1:0]     packed_result,
  output logic      [cfc_pkg::DOUBLE_WIDTH-1:0]   double_result
);
  import cfc_pkg::*;

  logic                     s_valid;
  op_t                      s_op;
  logic [DOUBLE_WIDTH-1:0]  s_dbl;
  logic [WORD_WIDTH-1:0]    s_word;
  logic [WORD_WIDTH-1:0]    enc;
  logic [DOUBLE_WIDTH-1:0]  dec;
  logic                     s_move;

  assign s_move   = s_valid && (!valid || !stall);
  assign in_stall = s_valid && !s_move;

  // Hold the input item
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (!in_stall) begin
      s_valid <= in_valid;
    end
    if (!in_stall && in_valid) begin
      s_op   <= op_t'(opcode);
      s_dbl  <= double_bits;
      s_word <= packed_word;
    end
  end

  cfc_encode #(.EXP_WIDTH(EXP_WIDTH)) u_enc (.double_bits(s_dbl), .packed_result(enc));
  cfc_decode #(.EXP_WIDTH(EXP_WIDTH)) u_dec (.packed_word(s_word), .double_result(dec));

  // Advance the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!valid || !stall) begin
      valid <= s_valid;
    end
    if (s_move) begin
      packed_result <= (s_op == OP_ENCODE) ? enc : '0;
      double_result <= (s_op == OP_DECODE) ? dec : '0;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    valid && stall |=> valid && $stable(packed_result) && $stable(double_result))
    else $error("result changed while stalled");
  a_one_field: assert property (@(posedge clk) disable iff (rst)
    valid |-> (packed_result == '0) || (double_result == '0))
    else $error("both result fields nonzero");
  a_no_stall_empty: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s_valid && valid)
    else $error("input stalled with free stage");
endmodule
`default_nettype wire

/* rtl/cfc_encode.sv */
`default_nettype none
module cfc_encode #(
  parameter int unsigned EXP_WIDTH = cfc_pkg::EXP_WIDTH_DEF
) (
  input  wire logic [cfc_pkg::DOUBLE_WIDTH-1:0] double_bits,
  output logic      [cfc_pkg::WORD_WIDTH-1:0]   packed_result
);
  import cfc_pkg::*;

  localparam int unsigned COEF_BITS = WORD_WIDTH - EXP_WIDTH;
  localparam int EXP_MIN = -(2 ** (EXP_WIDTH - 1));
  localparam int EXP_MAX = (2 ** (EXP_WIDTH - 1)) - 1;

  logic                  neg;
  logic [62:0]           mag;
  logic [BEXP_WIDTH-1:0] bexp;
  logic [FRAC_WIDTH-1:0] frac;
  logic [FRAC_WIDTH:0]   mant;
  logic [COEF_BITS-1:0]  lim;
  logic signed [12:0]    e2;
  logic signed [12:0]    ex;
  logic [6:0]            sh;
  logic [FRAC_WIDTH+1:0] rnd;
  logic [FRAC_WIDTH+1:0] coef_r;
  logic [COEF_BITS-1:0]  coef;
  logic [COEF_BITS-1:0]  coef_s;
  logic [EXP_WIDTH-1:0]  ex_out;

  // Scale, round half up, renormalise, then clamp the exponent
  always_comb begin
    neg    = double_bits[63];
    mag    = double_bits[62:0];
    bexp   = mag[62:52];
    frac   = mag[FRAC_WIDTH-1:0];
    mant   = {1'b1, frac};
    lim    = COEF_BITS'((2 ** (COEF_BITS - 1)) - 1) + COEF_BITS'(neg);
    e2     = $signed({2'b00, bexp}) - $signed({2'b00, BIAS});
    ex     = e2 + 13'sd1;
    if (ex < 0 && frac != '0) ex = ex + 13'sd1;
    // ex - e2 is 1 or 2, so the shift stays small
    sh     = 7'(13'(FRAC_WIDTH) + 13'(ex - e2) - 13'(COEF_BITS));
    rnd    = {1'b0, mant} + ((FRAC_WIDTH+2)'(1) << (sh - 7'd1));
    coef_r = rnd >> sh;
    // At most two halvings follow rounding
    if (coef_r > (FRAC_WIDTH+2)'(lim)) begin
      coef_r = coef_r >> 1;
      ex     = ex + 13'sd1;
    end
    if (coef_r > (FRAC_WIDTH+2)'(lim)) begin
      coef_r = coef_r >> 1;
      ex     = ex + 13'sd1;
    end
    coef   = coef_r[COEF_BITS-1:0];
    if (ex > 13'(EXP_MAX)) begin
      ex   = 13'(EXP_MAX);
      coef = lim;
    end else if (ex < 13'(EXP_MIN)) begin
      if ((ex + $signed(13'(COEF_BITS))) >= 13'(EXP_MIN)) begin
        coef = coef >> 13'(13'(EXP_MIN) - ex);
        ex   = 13'(EXP_MIN);
      end else begin
        ex   = '0;
        coef = '0;
      end
    end
    if (mag > HUGE_BITS) begin
      ex   = 13'(EXP_MAX);
      coef = lim;
    end
    coef_s = neg ? (COEF_BITS'(0) - coef) : coef;
    ex_out = ex[EXP_WIDTH-1:0];
    packed_result = {ex_out, coef_s};
    // NaN, and everything below the lower limit, gives zero
    if ((bexp == '1 && frac != '0) || mag < TINY_BITS) packed_result = '0;
  end
endmodule
`default_nettype wire

/* rtl/cfc_decode.sv */
`default_nettype none
module cfc_decode #(
  parameter int unsigned EXP_WIDTH = cfc_pkg::EXP_WIDTH_DEF
) (
  input  wire logic [cfc_pkg::WORD_WIDTH-1:0]   packed_word,
  output logic      [cfc_pkg::DOUBLE_WIDTH-1:0] double_result
);
  import cfc_pkg::*;

  localparam int unsigned COEF_BITS = WORD_WIDTH - EXP_WIDTH;

  logic [COEF_BITS-1:0]  craw;
  logic                  neg;
  logic [COEF_BITS-1:0]  m;
  logic signed [12:0]    ex;
  logic [4:0]            p;
  logic signed [12:0]    e2;
  logic [FRAC_WIDTH:0]   msh;

  // Find the leading one, then place it as the hidden bit
  always_comb begin
    craw = packed_word[COEF_BITS-1:0];
    neg  = craw[COEF_BITS-1];
    m    = neg ? (COEF_BITS'(0) - craw) : craw;
    ex   = 13'($signed(packed_word[WORD_WIDTH-1:COEF_BITS]));
    p    = '0;
    for (int i = 0; i < COEF_BITS; i++) begin
      if (m[i]) p = 5'(i);
    end
    e2   = 13'(p) + ex - 13'(COEF_BITS);
    msh  = (FRAC_WIDTH+1)'(m) << (6'(FRAC_WIDTH) - 6'(p));
    double_result = {neg, 11'(e2 + 13'sd1023), msh[FRAC_WIDTH-1:0]};
    if (m == '0) double_result = '0;
  end
endmodule
`default_nettype wire

/* sim/testbench.sv */
module testbench;
  import cfc_pkg::*;

  localparam int  COEF_W   = 25;
  localparam longint EXP_LO = -64;
  localparam longint EXP_HI = 63;
  localparam int  N_RANDOM = 1550;
  localparam logic [63:0] FRAC_M = (64'd1 << 52) - 1;

  // Scoreboard: predicts each conversion and checks results in order
  class codec_scoreboard;
    logic [31:0] want_packed[$];
    logic [63:0] want_double[$];
    int errors = 0;

    function automatic logic [31:0] encode_compact(logic [63:0] b);
      logic [62:0] mag;
      logic [63:0] mant, coef, lim;
      longint      e2, ex, sh;
      mag = b[62:0];
      lim = (64'd1 << (COEF_W - 1)) - 1 + b[63];
      // NaN and tiny magnitudes give zero
      if (b[62:52] == 11'h7FF && b[51:0] != 0) return 32'd0;
      if (mag < TINY_BITS) return 32'd0;
      if (mag > HUGE_BITS) begin
        ex   = EXP_HI;
        coef = lim;
      end else begin
        e2   = longint'(b[62:52]) - 1023;
        mant = {12'd1, b[51:0]};
        ex   = e2 + 1;
        if (ex < 0 && b[51:0] != 0) ex = ex + 1;
        sh   = 52 + ex - e2 - COEF_W;
        coef = (mant + (64'd1 << (sh - 1))) >> sh;
        while (coef > lim) begin
          coef = coef >> 1;
          ex   = ex + 1;
        end
        if (ex > EXP_HI) begin
          ex   = EXP_HI;
          coef = lim;
        end else if (ex < EXP_LO) begin
          if (ex + COEF_W >= EXP_LO) begin
            coef = coef >> (EXP_LO - ex);
            ex   = EXP_LO;
          end else begin
            ex   = 0;
            coef = 0;
          end
        end
      end
      // apply sign last
      if (b[63]) coef = 64'd0 - coef;
      return {ex[6:0], coef[COEF_W-1:0]};
    endfunction

    function automatic logic [63:0] decode_compact(logic [31:0] w);
      logic [63:0] m;
      logic        neg;
      longint      ex, e2;
      int          p;
      neg = w[COEF_W-1];
      m   = neg ? ((64'd1 << COEF_W) - {39'd0, w[COEF_W-1:0]}) : {39'd0, w[COEF_W-1:0]};
      ex  = longint'($signed(w[31:COEF_W]));
      p   = 0;
      if (m == 0) return 64'd0;
      while (p < 63 && (m >> (p + 1)) != 0) p++;
      e2 = p + ex - COEF_W;
      return ({63'd0, neg} << 63) | (64'(e2 + 1023) << 52) | ((m << (52 - p)) & FRAC_M);
    endfunction

    function void note(logic op, logic [63:0] dbits, logic [31:0] pword);
      if (op == OP_ENCODE) begin
        want_packed.push_back(encode_compact(dbits));
        want_double.push_back(64'd0);
      end else begin
        want_packed.push_back(32'd0);
        want_double.push_back(decode_compact(pword));
      end
    endfunction

    function void check(logic [31:0] got_p, logic [63:0] got_d);
      logic [31:0] ep;
      logic [63:0] ed;
      if (want_packed.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected transfer: packed %h double %h", got_p, got_d);
        return;
      end
      ep = want_packed.pop_front();
      ed = want_double.pop_front();
      if (got_p !== ep || got_d !== ed) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: packed exp %h got %h, double exp %h got %h",
                   ep, got_p, ed, got_d);
      end
    endfunction

    function int pending();
      return want_packed.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        opcode = 1'b0;
  logic [63:0] double_bits = 64'd0;
  logic [31:0] packed_word = 32'd0;
  logic        valid;
  logic        stall = 1'b0;
  logic [31:0] packed_result;
  logic [63:0] double_result;

  codec_scoreboard conv_board = new();
  int results_seen = 0;

  compact_float_codec_unit u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .double_bits(double_bits), .packed_word(packed_word),
    .valid(valid), .stall(stall),
    .packed_result(packed_result), .double_result(double_result)
  );

  always #5 clk = ~clk;

  // Offer one item, wait out any gap first, hold until the transfer
  task automatic send_item(logic op, logic [63:0] dbits, logic [31:0] pword, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    opcode      <= op;
    double_bits <= dbits;
    packed_word <= pword;
    do @(posedge clk); while (in_stall);
    conv_board.note(op, dbits, pword);
  endtask

  function automatic int draw_gap(int idx);
    if ((idx % 300) < 60) return 0;
    return $urandom_range(0, 13);
  endfunction

  function automatic logic [63:0] rand_double();
    logic [63:0] r;
    int unsigned bexp;
    r = {$urandom, $urandom};
    if ($urandom_range(0, 9) < 6) begin
      bexp = 1023 + $urandom_range(0, 720) - 360;
      r[62:52] = bexp[10:0];
    end
    return r;
  endfunction

  // Receiver: random stalls, one long hold-off to back up the block
  initial begin
    int n;
    @(negedge rst);
    forever begin
      if (results_seen == 500) n = 250;
      else if ((results_seen % 250) < 50) n = 0;
      else n = $urandom_range(0, 13);
      if (n > 0) begin
        stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      stall <= 1'b0;
      do @(posedge clk); while (!valid);
      conv_board.check(packed_result, double_result);
      results_seen++;
    end
  end

  // Stimulus: directed corners, then random items
  initial begin
    logic [63:0] dir_dbl[$];
    logic [31:0] dir_word[$];
    int k;
    dir_dbl = '{64'h0, 64'h8000000000000000, 64'h7FF8000000000001, 64'hFFF8000000000000,
                64'h7FF0000000000000, 64'hFFF0000000000000, {1'b0, TINY_BITS},
                {1'b0, TINY_BITS - 63'd1}, {1'b0, HUGE_BITS}, {1'b1, HUGE_BITS + 63'd1},
                64'h3FF0000000000000, 64'hBFF0000000000000, 64'h3FE0000000000000,
                64'h0000000000000001, 64'h4450000000000000, 64'hC170000000000000,
                64'h4170000000000000, 64'h3B90000000000000, 64'h39B0000000000000,
                64'h3FF0000008000000, 64'h3FFFFFFFFFFFFFFF};
    dir_word = '{32'h0, 32'h01000000, 32'h00FFFFFF, 32'h7E000001, 32'h80000001,
                 32'hFE000000, 32'hFFFFFFFF};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    foreach (dir_dbl[i]) send_item(OP_ENCODE, dir_dbl[i], $urandom, $urandom_range(0, 2));
    foreach (dir_word[i]) send_item(OP_DECODE, {$urandom, $urandom}, dir_word[i], 0);
    for (k = 0; k < N_RANDOM; k++) begin
      // pause until the block has drained
      if (k == 900) begin
        in_valid <= 1'b0;
        while (conv_board.pending() != 0) @(posedge clk);
      end
      send_item(logic'($urandom_range(0, 1)), rand_double(), $urandom, draw_gap(k));
    end
    in_valid <= 1'b0;
    while (conv_board.pending() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (conv_board.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #3000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
